// ----- hdl/dfr_pkg.sv -----
// Shared types, constants and mode decode for the length-prefixed message deframer.
// No dependencies; every other file in hdl/ imports this package.
package dfr_pkg;

	localparam int HDR_MAX     = 14;
	localparam int FIELD_BYTES = 10;
	localparam int MODE_COUNT  = 12;
	localparam int QUEUE_DEPTH = 4;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam logic [2:0] SIZE_WIDTH_TAB [MODE_COUNT] =
		'{3'd2, 3'd2, 3'd4, 3'd4, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd4, 3'd1, 3'd1};
	localparam logic [2:0] SIZE_INCL_TAB [MODE_COUNT] =
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd4, 3'd1, 3'd1};
	localparam logic [3:0] HDR_LEN_TAB [MODE_COUNT] =
		'{4'd12, 4'd12, 4'd14, 4'd14, 4'd11, 4'd11, 4'd12, 4'd12, 4'd14, 4'd14, 4'd11, 4'd11};

	typedef struct packed {
		logic [2:0] size_width;
		logic [2:0] incl;
		logic [3:0] hdr_len;
		logic       msb;
	} mode_t;

	// One queue slot: a decoded header or a single payload byte (in fbytes[0]).
	typedef struct packed {
		logic                          kind;
		logic                          last;
		logic                          err;
		logic                          msb;
		logic [31:0]                   plen;
		logic [FIELD_BYTES-1:0][7:0]   fbytes;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic mode_t mode_decode(input logic [3:0] head_mode);
		logic [3:0] m;
		mode_t      r;
		if (head_mode inside {[4'd12:4'd14]}) begin
			m = 4'd2;
		end else if (head_mode == 4'd15) begin
			m = 4'd0;
		end else begin
			m = head_mode;
		end
		r.size_width = SIZE_WIDTH_TAB[m];
		r.incl       = SIZE_INCL_TAB[m];
		r.hdr_len    = HDR_LEN_TAB[m];
		r.msb        = m[0];
		return r;
	endfunction

endpackage

// ----- hdl/dfr_front.sv -----
// Front end: accepts stream bytes, stores header bytes, sizes each message
// and classifies bytes as header or payload. Depends on dfr_pkg.
module dfr_front import dfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       q_ready,
	output logic       push,
	output entry_t     push_entry
);

	logic [3:0]  mode_q;
	logic [7:0]  hdr_q [HDR_MAX];
	logic [3:0]  pos_q;
	logic        in_pay_q;
	logic [31:0] rem_q;

	mode_t       md;
	logic        accept;
	logic        pay_byte;
	logic        hdr_done;
	logic [7:0]  view [HDR_MAX];
	logic [31:0] size_val;
	logic [33:0] diff;
	logic        err;
	logic [31:0] plen;
	logic [FIELD_BYTES-1:0][7:0] fb;

	assign md       = mode_decode(mode_q);
	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;
	assign pay_byte = in_pay_q && (rem_q != 32'd0);
	assign hdr_done = (5'(pos_q) + 5'd1) >= 5'(md.hdr_len);

	// Header view with the byte arriving now already in place.
	always_comb begin
		for (int i = 0; i < HDR_MAX; i++) begin
			view[i] = (pos_q == 4'(i)) ? in_byte : hdr_q[i];
		end
	end

	always_comb begin
		case (md.size_width)
			3'd2: size_val = md.msb ? {16'd0, view[0], view[1]} : {16'd0, view[1], view[0]};
			3'd4: size_val = md.msb ? {view[0], view[1], view[2], view[3]}
			                        : {view[3], view[2], view[1], view[0]};
			default: size_val = {24'd0, view[0]};
		endcase
	end

	always_comb begin
		for (int k = 0; k < FIELD_BYTES; k++) begin
			case (md.size_width)
				3'd2:    fb[k] = view[k + 2];
				3'd4:    fb[k] = view[k + 4];
				default: fb[k] = view[k + 1];
			endcase
		end
	end

	// Total size minus header length; a borrow flags a short message.
	assign diff = {2'b00, size_val} + 34'(md.incl) - 34'(md.hdr_len);
	assign err  = diff[33];
	assign plen = err ? 32'd0 : diff[31:0];

	always_comb begin
		push_entry = '0;
		if (pay_byte) begin
			push_entry.kind      = KIND_PAYLOAD;
			push_entry.last      = (rem_q == 32'd1);
			push_entry.fbytes[0] = in_byte;
		end else begin
			push_entry.kind   = KIND_HEADER;
			push_entry.last   = (plen == 32'd0);
			push_entry.err    = err;
			push_entry.msb    = md.msb;
			push_entry.plen   = plen;
			push_entry.fbytes = fb;
		end
	end

	assign push = accept && (pay_byte || hdr_done);

	always_ff @(posedge clk) begin
		if (accept && !pay_byte) begin
			hdr_q[pos_q] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 4'd0;
			pos_q    <= 4'd0;
			in_pay_q <= 1'b0;
			rem_q    <= 32'd0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				if (pay_byte) begin
					rem_q    <= rem_q - 32'd1;
					in_pay_q <= (rem_q != 32'd1);
				end else if (!hdr_done) begin
					in_pay_q <= 1'b0;
					pos_q    <= pos_q + 4'd1;
				end else begin
					pos_q    <= 4'd0;
					in_pay_q <= (plen != 32'd0);
					rem_q    <= plen;
				end
			end
		end
	end

	a_pay_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_pay_q |-> (rem_q != 32'd0))
		else $error("payload phase with zero remaining count");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 4'(HDR_MAX - 1))
		else $error("header position beyond header storage");

	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_entry.kind == KIND_HEADER && push_entry.err) |=> !in_pay_q)
		else $error("payload phase entered after short header");

endmodule

// ----- hdl/dfr_queue.sv -----
// Short flip-flop queue between the front end and the output stage.
// Depends on dfr_pkg for the default depth and entry width only.
module dfr_queue import dfr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH,
	parameter int W     = ENTRY_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         ready,
	output logic         valid,
	output logic [W-1:0] head,
	input  logic         pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign ready = (count_q != CW'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && ready) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && ready) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop && valid) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push && ready, pop && valid})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count overflow");

endmodule

// ----- hdl/dfr_back.sv -----
// Output stage: assembles header fields in the selected byte order and holds
// each result in a register until the sink takes it. Depends on dfr_pkg.
module dfr_back import dfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  entry_t       q_entry,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [127:0] out_data,
	output logic         out_last,
	output logic         out_kind
);

	logic         vld_q;
	logic [127:0] data_q;
	logic         last_q;
	logic         kind_q;

	logic [15:0]  ev;
	logic [31:0]  p1;
	logic [31:0]  p2;
	logic [7:0]   db;
	logic [127:0] nxt_data;
	logic         load;

	always_comb begin
		if (q_entry.msb) begin
			ev = {q_entry.fbytes[0], q_entry.fbytes[1]};
			p1 = {q_entry.fbytes[2], q_entry.fbytes[3], q_entry.fbytes[4], q_entry.fbytes[5]};
			p2 = {q_entry.fbytes[6], q_entry.fbytes[7], q_entry.fbytes[8], q_entry.fbytes[9]};
		end else begin
			ev = {q_entry.fbytes[1], q_entry.fbytes[0]};
			p1 = {q_entry.fbytes[5], q_entry.fbytes[4], q_entry.fbytes[3], q_entry.fbytes[2]};
			p2 = {q_entry.fbytes[9], q_entry.fbytes[8], q_entry.fbytes[7], q_entry.fbytes[6]};
		end
		db = q_entry.fbytes[0];
		if (q_entry.kind == KIND_PAYLOAD) begin
			nxt_data = {7'd0, 1'b0, db, 32'd0, 32'd0, 32'd0, 16'd0};
		end else begin
			nxt_data = {7'd0, q_entry.err, 8'd0, q_entry.plen, p2, p1, ev};
		end
	end

	// Refill the output register whenever it is empty or being drained.
	assign load      = q_valid && (!vld_q || out_ready);
	assign q_pop     = load;
	assign out_valid = vld_q;
	assign out_data  = data_q;
	assign out_last  = last_q;
	assign out_kind  = kind_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= nxt_data;
			last_q <= q_entry.last;
			kind_q <= q_entry.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	a_payload_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && kind_q == KIND_PAYLOAD) |-> (data_q[120] == 1'b0))
		else $error("length error flagged on payload byte");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && kind_q == KIND_HEADER && data_q[120]) |-> last_q)
		else $error("short header not marked last");

endmodule

// ----- hdl/length_prefixed_message_deframer.sv -----
// Top level of the length-prefixed message deframer: front end, queue, output stage.
// Depends on dfr_pkg, dfr_front, dfr_queue and dfr_back.
//
//   channel   handshake                       payload
//   s_axis    s_axis_tvalid / s_axis_tready   tdata[7:0] stream byte
//   m_axis    m_axis_tvalid / m_axis_tready   tdata fields, tuser kind, tlast
//   cfg       cfg_we                          cfg_wdata[3:0] header mode
//
// One byte is taken every cycle while the queue has room; a result reaches m_axis
// through a queue slot and then the output register.
// The queue holds QDEPTH results (default QUEUE_DEPTH), so a stalled sink blocks input only once
// that many results plus the output register are waiting.
// Reset clears the mode, header position and payload count; stored header bytes
// are not cleared and are always rewritten before use.
module length_prefixed_message_deframer import dfr_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata,      // head_mode
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] stream_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] event_code, [47:16] first_param, [79:48] second_param,
	// [111:80] payload_length, [119:112] data_byte, [120] length_error, rest zero
	output logic [127:0] m_axis_tdata,
	output logic [0:0]   m_axis_tuser,   // [0] kind
	output logic         m_axis_tlast
);

	logic         q_ready;
	logic         push;
	entry_t       push_entry;
	logic         q_valid;
	logic [ENTRY_W-1:0] q_head;
	entry_t       q_entry;
	logic         q_pop;
	logic         kind;

	dfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.q_ready    (q_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	dfr_queue #(
		.DEPTH (QDEPTH),
		.W     (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.ready     (q_ready),
		.valid     (q_valid),
		.head      (q_head),
		.pop       (q_pop)
	);

	assign q_entry = entry_t'(q_head);

	dfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_kind  (kind)
	);

	assign m_axis_tuser = kind;

endmodule

// ----- tb/length_prefixed_message_deframer_tb.sv -----
// Self-checking testbench for length_prefixed_message_deframer.
// Needs dfr_pkg and the deframer RTL. A built-in predictor tracks header assembly
// and payload counting, and every result on m_axis is compared against it.
module length_prefixed_message_deframer_tb;
	import dfr_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [15:0] event_code;
		logic [31:0] first_param;
		logic [31:0] second_param;
		logic [31:0] payload_length;
		logic [7:0]  data_byte;
		logic        last;
		logic        length_error;
	} deframe_result_t;

	typedef struct {
		int size_bytes;
		int incl;
		int hdr_len;
		bit msb;
	} frame_fmt_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [3:0]   cfg_wdata = 4'd0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'd0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         m_axis_tlast;

	length_prefixed_message_deframer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [3:0]  stream_mode = 4'd0;
	logic [7:0]  hdr_store [HDR_MAX];
	logic [3:0]  hdr_pos = 4'd0;
	bit          in_payload = 1'b0;
	logic [31:0] payload_left = 32'd0;
	logic [31:0] frame_size_plan = 32'd0;

	deframe_result_t expected_results [$];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int mismatch_count = 0;
	int results_checked = 0;
	int headers_seen = 0;
	int payload_seen = 0;
	int short_size_seen = 0;
	int bytes_sent = 0;
	logic [15:0] modes_written = 16'd0;

	function automatic frame_fmt_t format_of(input logic [3:0] hm);
		frame_fmt_t f;
		int m;
		if (hm >= 4'd12 && hm <= 4'd14) begin
			m = 2;
		end else if (hm == 4'd15) begin
			m = 0;
		end else begin
			m = int'(hm);
		end
		case (m % 6)
			0, 1: f.size_bytes = 2;
			2, 3: f.size_bytes = 4;
			default: f.size_bytes = 1;
		endcase
		f.incl = (m >= 6) ? f.size_bytes : 0;
		f.hdr_len = f.size_bytes + 10;
		f.msb = (m % 2) == 1;
		return f;
	endfunction

	// byte i of an n-byte field in wire order
	function automatic logic [7:0] field_byte(input logic [31:0] value, input int n,
			input int i, input bit msb);
		int shift;
		shift = msb ? 8 * (n - 1 - i) : 8 * i;
		return 8'(value >> shift);
	endfunction

	function automatic logic [31:0] hdr_field(input int off, input int n, input bit msb);
		logic [31:0] v;
		int idx;
		v = 32'd0;
		for (int i = 0; i < n; i++) begin
			idx = msb ? (off + i) : (off + n - 1 - i);
			v = {v[23:0], hdr_store[idx]};
		end
		return v;
	endfunction

	task automatic predict_byte(input logic [7:0] b);
		deframe_result_t r;
		frame_fmt_t f;
		logic [32:0] total;
		r = '0;
		if (in_payload && payload_left != 0) begin
			payload_left = payload_left - 32'd1;
			r.kind = KIND_PAYLOAD;
			r.data_byte = b;
			r.last = (payload_left == 0);
			if (payload_left == 0)
				in_payload = 1'b0;
			expected_results.push_back(r);
			return;
		end
		in_payload = 1'b0;
		hdr_store[hdr_pos] = b;
		// the format in force now decides when the header is complete
		f = format_of(stream_mode);
		if (int'(hdr_pos) + 1 < f.hdr_len) begin
			hdr_pos = hdr_pos + 4'd1;
			return;
		end
		hdr_pos = 4'd0;
		total = {1'b0, hdr_field(0, f.size_bytes, f.msb)} + 33'(f.incl);
		r.kind = KIND_HEADER;
		r.event_code = 16'(hdr_field(f.size_bytes, 2, f.msb));
		r.first_param = hdr_field(f.size_bytes + 2, 4, f.msb);
		r.second_param = hdr_field(f.size_bytes + 6, 4, f.msb);
		r.length_error = total < 33'(f.hdr_len);
		r.payload_length = r.length_error ? 32'd0 : 32'(total - 33'(f.hdr_len));
		r.last = (r.payload_length == 0);
		if (r.payload_length != 0) begin
			in_payload = 1'b1;
			payload_left = r.payload_length;
		end
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				results_checked, name, got, want));
	endtask

	// sample on the falling edge so nothing depends on event order at the rising edge
	always @(negedge clk) begin
		deframe_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result, tdata 0x%0h tuser %0b",
					m_axis_tdata, m_axis_tuser));
			end else begin
				want = expected_results.pop_front();
				compare_field("kind", 32'(m_axis_tuser[0]), 32'(want.kind));
				compare_field("event_code", 32'(m_axis_tdata[15:0]), 32'(want.event_code));
				compare_field("first_param", m_axis_tdata[47:16], want.first_param);
				compare_field("second_param", m_axis_tdata[79:48], want.second_param);
				compare_field("payload_length", m_axis_tdata[111:80], want.payload_length);
				compare_field("data_byte", 32'(m_axis_tdata[119:112]), 32'(want.data_byte));
				compare_field("length_error", 32'(m_axis_tdata[120]),
					32'(want.length_error));
				compare_field("tdata padding", 32'(m_axis_tdata[127:121]), 32'd0);
				compare_field("last", 32'(m_axis_tlast), 32'(want.last));
				if (want.kind == KIND_HEADER)
					headers_seen++;
				else
					payload_seen++;
				if (want.length_error)
					short_size_seen++;
			end
			results_checked++;
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

	// All stimulus tasks start and end right at a rising edge.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		predict_byte(b);
		bytes_sent++;
		@(posedge clk);
	endtask

	// hold the stream until every pending result is out, plus pipeline slack
	task automatic wait_for_quiet();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic [3:0] m);
		wait_for_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		stream_mode = m;
		modes_written[m] = 1'b1;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [31:0] pick_size(input frame_fmt_t f);
		int r;
		int base;
		r = $urandom_range(99);
		base = f.hdr_len - f.incl;
		if (r < 10)
			return 32'($urandom_range(base - 1));
		if (r < 20)
			return 32'(base);
		if (r < 95)
			return 32'(base + $urandom_range(24, 1));
		if (f.size_bytes == 1)
			return 32'($urandom_range(255));
		return 32'(base + $urandom_range(200, 25));
	endfunction

	// next byte of well-formed traffic, following the predictor's view of the stream
	function automatic logic [7:0] next_traffic_byte();
		frame_fmt_t f;
		if (in_payload && payload_left != 0)
			return pick_byte();
		f = format_of(stream_mode);
		if (hdr_pos == 0)
			frame_size_plan = pick_size(f);
		if (int'(hdr_pos) < f.size_bytes)
			return field_byte(frame_size_plan, f.size_bytes, int'(hdr_pos), f.msb);
		return pick_byte();
	endfunction

	task automatic finish_frame();
		while (hdr_pos != 0 || in_payload)
			send_byte(next_traffic_byte());
	endtask

	// send the first count bytes of a header laid out in the current format
	task automatic send_header(input logic [31:0] size, input logic [15:0] ev,
			input logic [31:0] p1, input logic [31:0] p2, input int count);
		frame_fmt_t f;
		logic [7:0] hb [HDR_MAX];
		int sw;
		f = format_of(stream_mode);
		sw = f.size_bytes;
		for (int i = 0; i < sw; i++)
			hb[i] = field_byte(size, sw, i, f.msb);
		for (int i = 0; i < 2; i++)
			hb[sw + i] = field_byte(32'(ev), 2, i, f.msb);
		for (int i = 0; i < 4; i++) begin
			hb[sw + 2 + i] = field_byte(p1, 4, i, f.msb);
			hb[sw + 6 + i] = field_byte(p2, 4, i, f.msb);
		end
		for (int i = 0; i < count && i < f.hdr_len; i++)
			send_byte(hb[i]);
	endtask

	task automatic send_message(input logic [31:0] size, input logic [15:0] ev,
			input logic [31:0] p1, input logic [31:0] p2);
		send_header(size, ev, p1, p2, HDR_MAX);
		while (in_payload)
			send_byte(pick_byte());
	endtask

	task automatic test_reset_mode();
		// no write yet: the reset format (2-byte size, LSB first) applies
		send_message(32'd15, 16'h0000, 32'h0000_0000, 32'h0000_0000);
		send_message(32'd12, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_all_modes();
		frame_fmt_t f;
		for (int m = 0; m < 16; m++) begin
			write_mode(4'(m));
			f = format_of(4'(m));
			send_message(32'(f.hdr_len - f.incl + $urandom_range(3)), 16'($urandom),
				$urandom, $urandom);
		end
	endtask

	task automatic test_length_edges();
		// size counts itself: total exactly the header length, one below, and zero
		write_mode(4'd6);
		send_message(32'd10, 16'h1234, 32'h0102_0304, 32'hA0B0_C0D0);
		send_message(32'd9, 16'h8001, 32'hFFFF_FFFF, 32'h0000_0001);
		send_message(32'd0, 16'h0000, 32'h0, 32'h0);
		write_mode(4'd3);
		send_message(32'd14, 16'hBEEF, 32'h1122_3344, 32'h5566_7788);
		send_message(32'd13, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_message(32'd15, 16'h0001, 32'h0, 32'hFFFF_FFFF);
		write_mode(4'd10);
		send_message(32'd0, 16'h5A5A, 32'h0, 32'h0);
		// largest one-byte size, MSB first, self-inclusive
		write_mode(4'd11);
		send_message(32'hFF, 16'hA5A5, 32'hDEAD_BEEF, 32'h0BAD_F00D);
	endtask

	task automatic test_mode_switch();
		// 14-byte header cut after 12 bytes, completed under an 11-byte format
		write_mode(4'd2);
		send_header(32'd20, 16'h0F0F, 32'h1234_5678, 32'h9ABC_DEF0, 12);
		write_mode(4'd4);
		finish_frame();
		// 11-byte header cut after 5 bytes, grown to a 12-byte format
		send_header(32'd30, 16'h0000, 32'hCAFE_0001, 32'h0, 5);
		write_mode(4'd0);
		finish_frame();
		// format change inside a payload keeps the remaining count
		send_header(32'd32, 16'h4242, 32'h1, 32'h2, HDR_MAX);
		repeat (5) send_byte(pick_byte());
		write_mode(4'd9);
		finish_frame();
		send_message(32'd13, 16'h7777, 32'h3, 32'h4);
	endtask

	task automatic test_random_traffic(input int n_bytes, input int src_pct, input int snk_pct);
		int start;
		int since_switch;
		src_idle_pct = src_pct;
		sink_stall_pct = snk_pct;
		start = bytes_sent;
		since_switch = bytes_sent;
		while (bytes_sent - start < n_bytes || hdr_pos != 0) begin
			// change the format now and then at a header boundary, often mid-payload
			if (hdr_pos == 0 && bytes_sent - since_switch >= 20) begin
				case ($urandom_range(3))
					0: write_mode(4'd0);
					1: write_mode(4'd15);
					default: write_mode(4'($urandom_range(15)));
				endcase
				since_switch = bytes_sent;
			end
			send_byte(next_traffic_byte());
		end
		wait_for_quiet();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_mode();
		test_all_modes();
		test_length_edges();
		test_mode_switch();
		wait_for_quiet();

		test_random_traffic(40, 0, 0);
		test_random_traffic(40, 84, 0);
		test_random_traffic(40, 0, 84);
		test_random_traffic(40, 17, 17);

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d stream bytes; checked %0d headers (%0d short size) and %0d payload bytes.",
			bytes_sent, headers_seen, short_size_seen, payload_seen);
		$display("Mode values written: 0x%04h; format changes mid-header and mid-payload exercised.",
			modes_written);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("ERROR: run did not finish in time, %0d results outstanding",
			expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
